// ===== design/dsl_pkg.sv =====
// dsl_pkg: request/result structs, codes and cell control for the depth sorted list.
// Depends on nothing; used by dsl_cell and depth_sorted_list_top.

package dsl_pkg;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_LIST   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [15:0]        handle;
		logic signed [15:0] depth_key;
	} req_t;

	typedef struct packed {
		logic [15:0]        out_handle;
		logic signed [15:0] out_depth;
		logic [1:0]         status;
		logic               last;
	} rsp_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [15:0] handle;
	} cell_ctl_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_LIST
	} fsm_t;

endpackage

// ===== design/depth_sorted_list_top.sv =====
// depth_sorted_list_top: sorted handle/depth list built as a chain of dsl_cell slots.
// Uses dsl_pkg and dsl_cell.
//
// Requests: a transfer happens on a rising edge with start high and busy low.
// req_type selects insert, remove by handle or list; depth_key is used by insert.
// Results: rsp is valid for one cycle while done is high; the receiver cannot stall.
// Insert and remove finish in the accepting cycle's edge: their single result
// appears in the cycle after the transfer, and a new request may follow at once,
// so these run at one request per cycle.
// Insert compares the key in every cell at once; the new entry drops into the
// first slot holding a greater depth (else the first free slot) and the slots behind shift back by one.
// Remove finds the first matching handle and the slots behind shift forward.
// List: busy is high in the list state (N entries); one entry a cycle is emitted from
// the head slot while the valid part of the chain rotates, so the order is
// restored when last is flagged. An empty list gives one result with status
// empty and no busy period.
// Reset clears every slot's valid bit and the entry count; payload is not reset.
// Inserts into a full list are dropped and flagged.

module depth_sorted_list_top
	import dsl_pkg::*;
#(
	parameter int CAPACITY   = 32,
	parameter int DEPTH_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic signed [DEPTH_BITS-1:0] key_fit;

	generate
		if (DEPTH_BITS >= 16) begin : g_wide
			assign key_fit = DEPTH_BITS'(req.depth_key);
		end else begin : g_sat
			localparam logic signed [15:0] KEY_HI = 16'((1 << (DEPTH_BITS - 1)) - 1);
			localparam logic signed [15:0] KEY_LO = -KEY_HI - 16'sd1;
			logic signed [15:0] key_clip;
			always_comb begin
				priority if (req.depth_key > KEY_HI) begin
					key_clip = KEY_HI;
				end else if (req.depth_key < KEY_LO) begin
					key_clip = KEY_LO;
				end else begin
					key_clip = req.depth_key;
				end
			end
			assign key_fit = key_clip[DEPTH_BITS-1:0];
		end
	endgenerate

	logic                         cell_valid [CAPACITY];
	logic                         cell_gt    [CAPACITY];
	logic                         cell_hit   [CAPACITY];
	logic [15:0]                  cell_handle[CAPACITY];
	logic signed [DEPTH_BITS-1:0] cell_depth [CAPACITY];
	logic [CAPACITY-1:0]          valid_vec;

	cell_ctl_t  ctl;
	fsm_t       state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] rem_q, rem_d;
	rsp_t       rsp_q, rsp_d;
	logic       done_q, done_d;
	logic       accept;
	logic       full;
	logic       found;

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic                         p_valid, p_gt, p_hit, n_valid;
			logic [15:0]                  p_handle, n_handle;
			logic signed [DEPTH_BITS-1:0] p_depth, n_depth;

			if (i == 0) begin : g_first
				assign p_valid  = 1'b1;
				assign p_gt     = 1'b0;
				assign p_hit    = 1'b0;
				assign p_handle = '0;
				assign p_depth  = '0;
			end else begin : g_mid
				assign p_valid  = cell_valid[i-1];
				assign p_gt     = cell_gt[i-1];
				assign p_hit    = cell_hit[i-1];
				assign p_handle = cell_handle[i-1];
				assign p_depth  = cell_depth[i-1];
			end

			if (i == CAPACITY - 1) begin : g_tail
				assign n_valid  = 1'b0;
				assign n_handle = '0;
				assign n_depth  = '0;
			end else begin : g_body
				assign n_valid  = cell_valid[i+1];
				assign n_handle = cell_handle[i+1];
				assign n_depth  = cell_depth[i+1];
			end

			dsl_cell #(
				.DEPTH_BITS(DEPTH_BITS)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.key        (key_fit),
				.prev_valid (p_valid),
				.prev_gt    (p_gt),
				.prev_hit   (p_hit),
				.prev_handle(p_handle),
				.prev_depth (p_depth),
				.next_valid (n_valid),
				.next_handle(n_handle),
				.next_depth (n_depth),
				.head_handle(cell_handle[0]),
				.head_depth (cell_depth[0]),
				.valid      (cell_valid[i]),
				.gt         (cell_gt[i]),
				.hit        (cell_hit[i]),
				.handle     (cell_handle[i]),
				.depth      (cell_depth[i])
			);

			assign valid_vec[i] = cell_valid[i];
		end
	endgenerate

	assign accept = start && (state_q == FSM_IDLE);
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign found  = cell_hit[CAPACITY-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		rem_d      = rem_q;
		done_d     = 1'b0;
		ctl.op     = CELL_HOLD;
		ctl.handle = req.handle;
		rsp_d.out_handle = req.handle;
		rsp_d.out_depth  = '0;
		rsp_d.status     = ST_OK;
		rsp_d.last       = 1'b1;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					unique case (req.req_type)
						REQ_INSERT: begin
							done_d = 1'b1;
							if (full) begin
								rsp_d.status = ST_FULL;
							end else begin
								ctl.op  = CELL_INSERT;
								count_d = count_q + 1'b1;
							end
						end
						REQ_REMOVE: begin
							done_d = 1'b1;
							ctl.op = CELL_REMOVE;
							if (found) begin
								count_d = count_q - 1'b1;
							end else begin
								rsp_d.status = ST_NOT_FOUND;
							end
						end
						REQ_LIST: begin
							if (count_q == '0) begin
								done_d       = 1'b1;
								rsp_d.status = ST_EMPTY;
							end else begin
								rem_d   = count_q;
								state_d = FSM_LIST;
							end
						end
						default: ;
					endcase
				end
			end
			FSM_LIST: begin
				ctl.op           = CELL_ROTATE;
				done_d           = 1'b1;
				rsp_d.out_handle = cell_handle[0];
				rsp_d.out_depth  = 16'(cell_depth[0]);
				rsp_d.last       = (rem_q == CNT_W'(1));
				rem_d            = rem_q - 1'b1;
				if (rem_q == CNT_W'(1)) begin
					state_d = FSM_IDLE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= rem_d;
		rsp_q <= rsp_d;
	end

	assign busy = (state_q == FSM_LIST);
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_count_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("entry count disagrees with valid cells");

	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + CAPACITY'(1))) == '0)
		else $error("valid cells not contiguous from head");

	a_list_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_LIST) |=> done_q)
		else $error("list cycle gave no result");

	a_list_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == FSM_LIST) && (rem_q == CNT_W'(1))) |=> (done_q && rsp_q.last
		&& (state_q == FSM_IDLE)))
		else $error("list did not end with last");
`endif

endmodule

// ===== design/dsl_cell.sv =====
// dsl_cell: one slot of the sorted chain, holding a handle and a depth.
// Shifts from its neighbours on insert, remove and list rotation. Uses dsl_pkg.

module dsl_cell
	import dsl_pkg::*;
#(
	parameter int DEPTH_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cell_ctl_t                    ctl,
	input  logic signed [DEPTH_BITS-1:0] key,
	input  logic                         prev_valid,
	input  logic                         prev_gt,
	input  logic                         prev_hit,
	input  logic [15:0]                  prev_handle,
	input  logic signed [DEPTH_BITS-1:0] prev_depth,
	input  logic                         next_valid,
	input  logic [15:0]                  next_handle,
	input  logic signed [DEPTH_BITS-1:0] next_depth,
	input  logic [15:0]                  head_handle,
	input  logic signed [DEPTH_BITS-1:0] head_depth,
	output logic                         valid,
	output logic                         gt,
	output logic                         hit,
	output logic [15:0]                  handle,
	output logic signed [DEPTH_BITS-1:0] depth
);

	logic                         valid_q;
	logic [15:0]                  handle_q;
	logic signed [DEPTH_BITS-1:0] depth_q;
	logic                         valid_d;
	logic [15:0]                  handle_d;
	logic signed [DEPTH_BITS-1:0] depth_d;

	assign gt  = valid_q && (depth_q > key);
	assign hit = prev_hit || (valid_q && (handle_q == ctl.handle));

	always_comb begin
		valid_d  = valid_q;
		handle_d = handle_q;
		depth_d  = depth_q;
		unique case (ctl.op)
			CELL_INSERT: begin
				if (prev_gt) begin
					valid_d  = 1'b1;
					handle_d = prev_handle;
					depth_d  = prev_depth;
				end else if (prev_valid && (!valid_q || gt)) begin
					valid_d  = 1'b1;
					handle_d = ctl.handle;
					depth_d  = key;
				end
			end
			CELL_REMOVE: begin
				if (hit) begin
					valid_d  = next_valid;
					handle_d = next_handle;
					depth_d  = next_depth;
				end
			end
			CELL_ROTATE: begin
				if (valid_q) begin
					handle_d = next_valid ? next_handle : head_handle;
					depth_d  = next_valid ? next_depth : head_depth;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		handle_q <= handle_d;
		depth_q  <= depth_d;
	end

	assign valid  = valid_q;
	assign handle = handle_q;
	assign depth  = depth_q;

endmodule
